>>> rtl/core/urc_pkg.sv
// Package for the ultrasonic ranger controller: event kind codes,
// register indexes, reset values and the divide-by-58 constants.
// No dependencies.
package urc_pkg;

  localparam logic [1:0] KIND_FAST_TICK = 2'd0;
  localparam logic [1:0] KIND_ECHO_EDGE = 2'd1;
  localparam logic [1:0] KIND_SLOW_TICK = 2'd2;

  localparam logic [1:0] REG_TRIGGER_PERIOD  = 2'd0;
  localparam logic [1:0] REG_REPORT_PERIOD   = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_RELOAD = 2'd2;

  localparam logic [7:0] TRIGGER_PERIOD_RESET  = 8'd147;
  localparam logic [5:0] REPORT_PERIOD_RESET   = 6'd50;
  localparam logic [3:0] DEBOUNCE_RELOAD_RESET = 4'd10;
  localparam logic [5:0] REPORT_START          = 6'd30;

  // Widths below 256 * 58 fit in 14 bits; anything at or above saturates.
  localparam int unsigned ECHO_DIVISOR = 58;
  localparam logic [15:0] SAT_LIMIT    = 16'(256 * ECHO_DIVISOR);
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam logic [14:0] RECIP        = 15'(((1 << RECIP_SHIFT) + ECHO_DIVISOR - 1)
                                             / ECHO_DIVISOR);

  typedef struct packed {
    logic       trigger_level;
    logic [7:0] distance;
    logic       echo_done;
    logic       report_valid;
    logic       led_on;
  } result_t;

endpackage

>>> rtl/core/ultrasonic_ranger_controller_top.sv
// Ultrasonic ranger controller: trigger timing, echo capture and ranging,
// report pacing and button debounce with LED toggle.
// Depends on urc_pkg.
// Each result word is registered when its input word is accepted.
// Throughput: one word per cycle while out_ready does not stall the output; the output register is
// refilled in the same cycle it is emptied. Reset is synchronous and needs no clearing pass.
module ultrasonic_ranger_controller_top
  import urc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] capture_time,
  input  logic        button_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger_level,
  output logic [7:0]  distance,
  output logic        echo_done,
  output logic        report_valid,
  output logic        led_on
);

  logic [7:0]  trigger_period;
  logic [5:0]  report_period;
  logic [3:0]  debounce_reload;

  logic [7:0]  trigger_countdown, trigger_countdown_next;
  logic        trigger_armed, trigger_armed_next;
  logic        trigger_pin, trigger_pin_next;
  logic        awaiting_fall, awaiting_fall_next;
  logic        fall_seen, fall_seen_next;
  logic [15:0] rise_time, rise_time_next;
  logic [7:0]  distance_store, distance_store_next;
  logic [5:0]  report_countdown, report_countdown_next;
  logic [3:0]  debounce_count, debounce_count_next;
  logic        press_latched, press_latched_next;
  logic        led_state, led_state_next;
  logic        report;

  result_t     result;

  logic        accept;
  logic [7:0]  trig_dec;
  logic [5:0]  rep_dec;
  logic        start;
  logic [15:0] echo_width;
  logic [28:0] product;
  logic [7:0]  quotient;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign trig_dec   = trigger_countdown - 8'd1;
  assign rep_dec    = report_countdown - 6'd1;
  assign start      = (trig_dec == 8'd0);
  assign echo_width = capture_time - rise_time;
  assign product    = 29'(echo_width[13:0]) * 29'(RECIP);
  assign quotient   = (echo_width >= SAT_LIMIT) ? 8'hFF : product[RECIP_SHIFT +: 8];

  always_comb begin
    trigger_countdown_next = trigger_countdown;
    trigger_armed_next     = trigger_armed;
    trigger_pin_next       = trigger_pin;
    awaiting_fall_next     = awaiting_fall;
    fall_seen_next         = fall_seen;
    rise_time_next         = rise_time;
    distance_store_next    = distance_store;
    report_countdown_next  = report_countdown;
    debounce_count_next    = debounce_count;
    press_latched_next     = press_latched;
    led_state_next         = led_state;
    report                 = 1'b0;
    case (kind)
      KIND_FAST_TICK: begin
        trigger_countdown_next = start ? trigger_period : trig_dec;
        if (trigger_armed) begin
          trigger_armed_next = !trigger_pin;
          trigger_pin_next   = !trigger_pin;
        end
        if (start) begin
          trigger_armed_next = 1'b1;
          awaiting_fall_next = 1'b0;
          fall_seen_next     = 1'b0;
        end
      end
      KIND_ECHO_EDGE: begin
        if (!awaiting_fall) begin
          rise_time_next     = capture_time;
          awaiting_fall_next = 1'b1;
        end else begin
          fall_seen_next      = 1'b1;
          distance_store_next = quotient;
        end
      end
      KIND_SLOW_TICK: begin
        report                = (rep_dec == 6'd0);
        report_countdown_next = report ? report_period : rep_dec;
        if (button_pressed) begin
          if (debounce_count != 4'd0) begin
            debounce_count_next = debounce_count - 4'd1;
          end else begin
            press_latched_next = 1'b1;
          end
        end else begin
          debounce_count_next = debounce_reload;
        end
      end
      default: begin
      end
    endcase
    if (press_latched_next && !button_pressed) begin
      press_latched_next = 1'b0;
      led_state_next     = !led_state;
    end
    result.trigger_level = trigger_pin_next;
    result.distance      = distance_store_next;
    result.echo_done     = fall_seen_next;
    result.report_valid  = report;
    result.led_on        = led_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_period  <= TRIGGER_PERIOD_RESET;
      report_period   <= REPORT_PERIOD_RESET;
      debounce_reload <= DEBOUNCE_RELOAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRIGGER_PERIOD:  trigger_period  <= cfg_data;
        REG_REPORT_PERIOD:   report_period   <= cfg_data[5:0];
        REG_DEBOUNCE_RELOAD: debounce_reload <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_countdown <= TRIGGER_PERIOD_RESET;
      trigger_armed     <= 1'b0;
      trigger_pin       <= 1'b0;
      awaiting_fall     <= 1'b0;
      fall_seen         <= 1'b0;
      rise_time         <= 16'd0;
      distance_store    <= 8'd0;
      report_countdown  <= REPORT_START;
      debounce_count    <= DEBOUNCE_RELOAD_RESET;
      press_latched     <= 1'b0;
      led_state         <= 1'b0;
    end else if (accept) begin
      trigger_countdown <= trigger_countdown_next;
      trigger_armed     <= trigger_armed_next;
      trigger_pin       <= trigger_pin_next;
      awaiting_fall     <= awaiting_fall_next;
      fall_seen         <= fall_seen_next;
      rise_time         <= rise_time_next;
      distance_store    <= distance_store_next;
      report_countdown  <= report_countdown_next;
      debounce_count    <= debounce_count_next;
      press_latched     <= press_latched_next;
      led_state         <= led_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_level <= result.trigger_level;
      distance      <= result.distance;
      echo_done     <= result.echo_done;
      report_valid  <= result.report_valid;
      led_on        <= result.led_on;
    end
  end

`ifndef NO_ASSERTIONS
  a_pin_needs_arm: assert property (@(posedge clk) disable iff (rst)
    trigger_pin |-> trigger_armed)
    else $error("trigger pin high while not armed");

  a_fall_after_rise: assert property (@(posedge clk) disable iff (rst)
    fall_seen |-> awaiting_fall)
    else $error("echo fall recorded without a rise");

  a_second_edge_done: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_ECHO_EDGE && awaiting_fall |=> fall_seen && echo_done)
    else $error("second echo edge did not complete the measurement");

  a_report_slow_only: assert property (@(posedge clk) disable iff (rst)
    accept && kind != KIND_SLOW_TICK |=> !report_valid)
    else $error("report issued on a word that is not a slow tick");
`endif

endmodule
